>>> sv/smx_pkg.sv
// Shared types and constants for the stack machine execute block.
// No dependencies; imported by smx_divsqrt and stack_machine_execute_top.
package smx_pkg;

  localparam int STACK_DEPTH_D = 64;
  localparam int CALL_DEPTH_D  = 32;
  localparam int NUM_REGS_D    = 8;
  localparam int MEM_WORDS_D   = 1024;

  typedef enum logic [4:0] {
    OP_HLT   = 5'd0,  OP_PUSH  = 5'd1,  OP_ADD   = 5'd2,  OP_SUB   = 5'd3,
    OP_MUL   = 5'd4,  OP_DIV   = 5'd5,  OP_SQRT  = 5'd6,  OP_IN    = 5'd7,
    OP_OUT   = 5'd8,  OP_JMP   = 5'd9,  OP_JB    = 5'd10, OP_JBE   = 5'd11,
    OP_JA    = 5'd12, OP_JAE   = 5'd13, OP_JE    = 5'd14, OP_JNE   = 5'd15,
    OP_CALL  = 5'd16, OP_RET   = 5'd17, OP_PUSHR = 5'd18, OP_POPR  = 5'd19,
    OP_PUSHM = 5'd20, OP_POPM  = 5'd21, OP_DRAW  = 5'd22
  } op_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,  ST_HALTED  = 4'd1,  ST_FINISHED = 4'd2,
    ST_STK_OVF  = 4'd3,  ST_STK_UNF = 4'd4,  ST_CALL_OVF = 4'd5,
    ST_CALL_UNF = 4'd6,  ST_BAD_REG = 4'd7,  ST_BAD_ADDR = 4'd8,
    ST_DIV_ZERO = 4'd9,  ST_NEG_SQRT = 4'd10, ST_BAD_OP  = 4'd11
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EX, S_IT, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } du_req_t;

endpackage

>>> sv/stack_machine_execute_top.sv
// Stack machine execute unit: one instruction per request.
// Depends on smx_pkg and smx_divsqrt.
//
//   channel  ports                                   direction
//   in       in_valid/in_ready, in_kind, in_operand_word, in_console_value   in
//   out      out_valid/out_ready, out_next_address, out_out_valid,
//            out_out_value, out_status                                         out
//   cfg      cfg_we, cfg_data (program_length)       in
//
// Most instructions pass through the accept, memory read, execute and output load
// states in turn; div and sqrt also pass through the iterative unit.
// After reset the data memory is cleared one word a cycle, all MEM_WORDS words,
// with in_ready low. A stalled result holds the block in its output state.
module stack_machine_execute_top #(
  parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_D,
  parameter int CALL_DEPTH  = smx_pkg::CALL_DEPTH_D,
  parameter int NUM_REGS    = smx_pkg::NUM_REGS_D,
  parameter int MEM_WORDS   = smx_pkg::MEM_WORDS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_kind,
  input  logic signed [31:0] in_operand_word,
  input  logic signed [31:0] in_console_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_next_address,
  output logic        out_out_valid,
  output logic signed [31:0] out_out_value,
  output logic [3:0]  out_status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import smx_pkg::*;

  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int RDW = $clog2(CALL_DEPTH + 1);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int MW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  state_t state_r, state_nxt;

  logic [4:0]  kind_r;
  logic [31:0] opw_r, cv_r;
  logic [15:0] plen_r, pc_r;
  logic        stop_r;
  logic [DW-1:0]  dd_r;
  logic [RDW-1:0] rd_r;
  logic [31:0] regs_r [NUM_REGS];

  logic        clr_busy_r;
  logic [MW-1:0] clr_cnt_r;

  logic [15:0] res_addr_r;
  logic        res_ov_r;
  logic [31:0] res_oval_r;
  logic [3:0]  res_st_r;
  logic        out_valid_r;
  logic [SW-1:0] pend_wa_r;

  // memories and their read data
  logic [31:0] stk_mem [STACK_DEPTH];
  logic [15:0] ret_mem [CALL_DEPTH];
  logic [31:0] dat_mem [MEM_WORDS];
  logic [31:0] stk_a_q, stk_b_q, mem_q;
  logic [15:0] ret_q;

  logic [SW-1:0] stk_ra_a, stk_ra_b;
  logic [CW-1:0] ret_ra;
  logic [RW-1:0] reg_id;
  logic [31:0]   reg_val;
  logic          reg_ok, idx_ok;
  logic [MW-1:0] mem_idx;

  // execute decisions
  logic [15:0]   x_addr;
  logic [3:0]    x_st;
  logic          x_ov, x_good, x_iter;
  logic [31:0]   x_oval;
  logic          x_stk_we;
  logic [SW-1:0] x_stk_wa;
  logic [31:0]   x_stk_wd;
  logic [DW-1:0] x_dd;
  logic          x_ret_we;
  logic [RDW-1:0] x_rd;
  logic          x_reg_we, x_mem_we;
  du_req_t       du_req;
  logic          du_done;
  logic [31:0]   du_res;

  logic          stk_we;
  logic [SW-1:0] stk_wa;
  logic [31:0]   stk_wd;
  logic          mem_we;
  logic [MW-1:0] mem_wa;
  logic [31:0]   mem_wd;

  logic [15:0] pc1, pc2, tgt;
  logic signed [31:0] sa, sb;
  logic take;
  logic [31:0] arith;

  assign in_ready = (state_r == S_IDLE) && !clr_busy_r;

  assign stk_ra_b = SW'(dd_r - DW'(1));
  assign stk_ra_a = SW'(dd_r - DW'(2));
  assign ret_ra   = CW'(rd_r - RDW'(1));
  assign reg_id   = opw_r[RW-1:0];
  assign reg_ok   = !opw_r[31] && (opw_r < 32'(NUM_REGS));
  assign reg_val  = regs_r[reg_id];
  assign idx_ok   = !reg_val[31] && (reg_val < 32'(MEM_WORDS));
  assign mem_idx  = reg_val[MW-1:0];

  assign pc1 = pc_r + 16'd1;
  assign pc2 = pc_r + 16'd2;
  assign tgt = opw_r[15:0];
  assign sa  = stk_a_q;
  assign sb  = stk_b_q;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = S_RD;
      S_RD:   state_nxt = S_EX;
      S_EX:   state_nxt = x_iter ? S_IT : S_OUT;
      S_IT:   if (du_done) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // execute: decode, checks and state updates of one instruction
  always_comb begin
    x_addr   = pc1;
    x_st     = ST_OK;
    x_ov     = 1'b0;
    x_oval   = '0;
    x_iter   = 1'b0;
    x_stk_we = 1'b0;
    x_stk_wa = SW'(dd_r);
    x_stk_wd = '0;
    x_dd     = dd_r;
    x_ret_we = 1'b0;
    x_rd     = rd_r;
    x_reg_we = 1'b0;
    x_mem_we = 1'b0;
    du_req   = '0;
    take     = 1'b0;
    arith    = '0;

    unique case (kind_r)
      OP_HLT: x_st = ST_HALTED;
      OP_PUSH, OP_IN: begin
        if (kind_r == OP_PUSH) x_addr = pc2;
        if (dd_r >= DW'(STACK_DEPTH)) x_st = ST_STK_OVF;
        else begin
          x_stk_we = 1'b1;
          x_stk_wd = (kind_r == OP_PUSH) ? opw_r : cv_r;
          x_dd     = dd_r + DW'(1);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        unique case (kind_r)
          OP_ADD:  arith = stk_a_q + stk_b_q;
          OP_SUB:  arith = stk_a_q - stk_b_q;
          OP_MUL:  arith = stk_a_q * stk_b_q;
          default: arith = '0;
        endcase
        if (dd_r < DW'(2)) x_st = ST_STK_UNF;
        else if (kind_r == OP_DIV && stk_b_q == 32'd0) x_st = ST_DIV_ZERO;
        else begin
          x_stk_wa = stk_ra_a;
          x_dd     = dd_r - DW'(1);
          if (kind_r == OP_DIV) begin
            x_iter       = 1'b1;
            du_req.start = 1'b1;
          end else begin
            x_stk_we = 1'b1;
            x_stk_wd = arith;
          end
        end
      end
      OP_SQRT: begin
        if (dd_r == '0) x_st = ST_STK_UNF;
        else if (stk_b_q[31]) x_st = ST_NEG_SQRT;
        else begin
          x_stk_wa       = stk_ra_b;
          x_iter         = 1'b1;
          du_req.start   = 1'b1;
          du_req.is_sqrt = 1'b1;
        end
      end
      OP_OUT: begin
        if (dd_r == '0) x_st = ST_STK_UNF;
        else begin
          x_ov   = 1'b1;
          x_oval = stk_b_q;
          x_dd   = dd_r - DW'(1);
        end
      end
      OP_JMP: x_addr = tgt;
      OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
        unique case (kind_r)
          OP_JB:   take = sa < sb;
          OP_JBE:  take = sa <= sb;
          OP_JA:   take = sa > sb;
          OP_JAE:  take = sa >= sb;
          OP_JE:   take = sa == sb;
          default: take = sa != sb;
        endcase
        if (dd_r < DW'(2)) x_st = ST_STK_UNF;
        else begin
          x_dd   = dd_r - DW'(2);
          x_addr = take ? tgt : pc2;
        end
      end
      OP_CALL: begin
        if (rd_r >= RDW'(CALL_DEPTH)) x_st = ST_CALL_OVF;
        else begin
          x_ret_we = 1'b1;
          x_rd     = rd_r + RDW'(1);
          x_addr   = tgt;
        end
      end
      OP_RET: begin
        if (rd_r == '0) x_st = ST_CALL_UNF;
        else begin
          x_rd   = rd_r - RDW'(1);
          x_addr = ret_q;
        end
      end
      OP_PUSHR, OP_POPR, OP_PUSHM, OP_POPM: begin
        x_addr = pc2;
        if (!reg_ok) x_st = ST_BAD_REG;
        else if ((kind_r == OP_PUSHM || kind_r == OP_POPM) && !idx_ok) x_st = ST_BAD_ADDR;
        else if (kind_r == OP_PUSHR || kind_r == OP_PUSHM) begin
          if (dd_r >= DW'(STACK_DEPTH)) x_st = ST_STK_OVF;
          else begin
            x_stk_we = 1'b1;
            x_stk_wd = (kind_r == OP_PUSHR) ? reg_val : mem_q;
            x_dd     = dd_r + DW'(1);
          end
        end else begin
          if (dd_r == '0) x_st = ST_STK_UNF;
          else begin
            x_dd     = dd_r - DW'(1);
            x_reg_we = (kind_r == OP_POPR);
            x_mem_we = (kind_r == OP_POPM);
          end
        end
      end
      OP_DRAW: x_addr = pc2;
      default: x_st = ST_BAD_OP;
    endcase

    // stopped machine or program end: no state change at all
    if (stop_r || pc_r >= plen_r) begin
      x_addr = pc_r;
      x_st   = (pc_r >= plen_r) ? ST_FINISHED : ST_HALTED;
    end
    x_good = (x_st == ST_OK);
    if (!x_good) begin
      x_ov = 1'b0; x_oval = '0; x_iter = 1'b0; x_stk_we = 1'b0; x_dd = dd_r;
      x_ret_we = 1'b0; x_rd = rd_r; x_reg_we = 1'b0; x_mem_we = 1'b0;
      du_req = '0;
      if (!(stop_r || pc_r >= plen_r)) x_addr = pc_r;
    end else if (x_addr >= plen_r) begin
      x_st = ST_FINISHED;
    end
    if (state_r != S_EX) begin
      x_iter = 1'b0; x_stk_we = 1'b0; x_ret_we = 1'b0; x_reg_we = 1'b0;
      x_mem_we = 1'b0; du_req = '0;
    end
  end

  smx_divsqrt u_du (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (du_req),
    .opa  (du_req.is_sqrt ? stk_b_q : stk_a_q),
    .opb  (stk_b_q),
    .done (du_done),
    .res  (du_res)
  );

  // write port selection
  always_comb begin
    if (state_r == S_IT && du_done) begin
      stk_we = 1'b1;
      stk_wa = pend_wa_r;
      stk_wd = du_res;
    end else begin
      stk_we = x_stk_we;
      stk_wa = x_stk_wa;
      stk_wd = x_stk_wd;
    end
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = x_mem_we;
      mem_wa = mem_idx;
      mem_wd = stk_b_q;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_a_q <= stk_mem[stk_ra_a];
    stk_b_q <= stk_mem[stk_ra_b];
  end

  always_ff @(posedge clk) begin
    if (x_ret_we) ret_mem[CW'(rd_r)] <= pc2;
    ret_q <= ret_mem[ret_ra];
  end

  always_ff @(posedge clk) begin
    if (mem_we) dat_mem[mem_wa] <= mem_wd;
    mem_q <= dat_mem[mem_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      plen_r      <= '0;
      pc_r        <= '0;
      stop_r      <= 1'b0;
      dd_r        <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) plen_r <= cfg_data;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + MW'(1);
        if (clr_cnt_r == MW'(MEM_WORDS - 1)) clr_busy_r <= 1'b0;
      end
      if (state_r == S_EX) begin
        dd_r <= x_dd;
        rd_r <= x_rd;
        if (x_st != ST_OK) stop_r <= 1'b1;
        if (x_good) pc_r <= x_addr;
      end
      if (x_reg_we) regs_r[reg_id] <= stk_b_q;
      // drop a taken result, load a new one when the slot is free
      if (state_r == S_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_ready) begin
      kind_r <= in_kind;
      opw_r  <= in_operand_word;
      cv_r   <= in_console_value;
    end
    if (state_r == S_EX) begin
      res_addr_r <= x_addr;
      res_ov_r   <= x_ov;
      res_oval_r <= x_oval;
      res_st_r   <= x_st;
      pend_wa_r  <= x_stk_wa;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_next_address <= res_addr_r;
      out_out_valid    <= res_ov_r;
      out_out_value    <= res_oval_r;
      out_status       <= res_st_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dd_r <= DW'(STACK_DEPTH))
    else $error("data stack depth out of range");
  a_call_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_r <= RDW'(CALL_DEPTH))
    else $error("call stack depth out of range");
  a_iter_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IT && du_done) |=> state_r == S_OUT)
    else $error("iterative result not committed");
`endif

endmodule

>>> sv/smx_divsqrt.sv
// Iterative signed divider and integer square root, one bit of quotient
// or one root digit per cycle. Depends on smx_pkg.
module smx_divsqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  smx_pkg::du_req_t req,
  input  logic [31:0]     opa,
  input  logic [31:0]     opb,
  output logic            done,
  output logic [31:0]     res
);
  import smx_pkg::*;

  logic        busy_r, done_r, neg_r, sq_r;
  logic [5:0]  cnt_r;
  logic [33:0] rem_r;
  logic [31:0] src_r, root_r, dvs_r;
  logic [32:0] dt;
  logic [33:0] st, trial;
  logic        ge;

  always_comb begin
    dt    = {rem_r[31:0], src_r[31]};
    st    = {rem_r[31:0], src_r[31:30]};
    trial = {root_r, 2'b01};
    ge    = sq_r ? (st >= trial) : (dt >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.is_sqrt ? 6'd16 : 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sq_r   <= req.is_sqrt;
      neg_r  <= opa[31] ^ opb[31];
      src_r  <= (req.is_sqrt || !opa[31]) ? opa : (32'd0 - opa);
      dvs_r  <= opb[31] ? (32'd0 - opb) : opb;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      if (sq_r) begin
        src_r  <= {src_r[29:0], 2'b00};
        rem_r  <= ge ? (st - trial) : st;
        root_r <= {root_r[30:0], ge};
      end else begin
        src_r  <= {src_r[30:0], 1'b0};
        rem_r  <= {1'b0, ge ? (dt - {1'b0, dvs_r}) : dt};
        root_r <= {root_r[30:0], ge};
      end
    end
  end

  assign done = done_r;
  assign res  = (!sq_r && neg_r) ? (32'd0 - root_r) : root_r;

endmodule
